// File: rtl/wfc_pkg.sv
`default_nettype none

package wfc_pkg;

  // Number of distinct work item identifiers (one link entry each)
  localparam int ITEMS  = 64;
  localparam int ID_W   = 6;
  localparam int CNT_W  = 7;
  localparam int KIND_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_ENQ    = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_DEQ    = 2'd2
  } kind_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   item_id;
    logic              handler_valid;
  } op_t;

  typedef struct packed {
    logic              status;
    logic              got_item;
    logic [ID_W-1:0]   taken_id;
    logic [CNT_W-1:0]  queued_count;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/wfc_if.sv
`default_nettype none

interface wfc_in_if;
  logic                      valid;
  logic                      ready;
  logic [wfc_pkg::KIND_W-1:0] kind;
  logic [wfc_pkg::ID_W-1:0]   item_id;
  logic                      handler_valid;

  modport source (output valid, kind, item_id, handler_valid, input ready);
  modport sink   (input valid, kind, item_id, handler_valid, output ready);
endinterface

interface wfc_out_if;
  logic                      valid;
  logic                      ready;
  logic                      status;
  logic                      got_item;
  logic [wfc_pkg::ID_W-1:0]   taken_id;
  logic [wfc_pkg::CNT_W-1:0]  queued_count;

  modport source (output valid, status, got_item, taken_id, queued_count, input ready);
  modport sink   (input valid, status, got_item, taken_id, queued_count, output ready);
endinterface

`default_nettype wire

// File: rtl/wfc_ram.sv
`default_nettype none

module wfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/wfc_ctrl.sv
`default_nettype none

module wfc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  wfc_pkg::op_t  op_i,
  output logic          idle_o,
  output logic          done_o,
  output wfc_pkg::res_t res_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DEQ  = 4'b0010,
    ST_LINK = 4'b0100,
    ST_WALK = 4'b1000
  } state_e;

  state_e                    state_q, state_d;
  logic [wfc_pkg::ID_W-1:0]  head_q, head_d;
  logic [wfc_pkg::ID_W-1:0]  tail_q, tail_d;
  logic [wfc_pkg::CNT_W-1:0] count_q, count_d;
  logic [wfc_pkg::ITEMS-1:0] pend_q, pend_d;
  logic [wfc_pkg::ID_W-1:0]  id_q, id_d;
  logic [wfc_pkg::ID_W-1:0]  nid_q, nid_d;
  logic [wfc_pkg::ID_W-1:0]  prev_q, prev_d;

  logic                      ram_we;
  logic [wfc_pkg::ID_W-1:0]  ram_waddr;
  logic [wfc_pkg::ID_W-1:0]  ram_wdata;
  logic [wfc_pkg::ID_W-1:0]  ram_raddr;
  logic [wfc_pkg::ID_W-1:0]  ram_rdata;
  logic                      cancel_fin;

  wfc_ram #(
    .WIDTH (wfc_pkg::ID_W),
    .DEPTH (wfc_pkg::ITEMS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    pend_d     = pend_q;
    id_d       = id_q;
    nid_d      = nid_q;
    prev_d     = prev_q;
    ram_we     = 1'b0;
    ram_waddr  = tail_q;
    ram_wdata  = op_i.item_id;
    ram_raddr  = head_q;
    cancel_fin = 1'b0;
    done_o     = 1'b0;
    res_o      = '0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (wfc_pkg::kind_e'(op_i.kind))
            wfc_pkg::KIND_ENQ: begin
              done_o = 1'b1;
              if (!op_i.handler_valid) begin
                res_o.status = 1'b1;
              end else if (!pend_q[op_i.item_id]) begin
                pend_d[op_i.item_id] = 1'b1;
                if (count_q == '0) begin
                  head_d = op_i.item_id;
                end else begin
                  // append behind the current tail
                  ram_we    = 1'b1;
                  ram_waddr = tail_q;
                  ram_wdata = op_i.item_id;
                end
                tail_d  = op_i.item_id;
                count_d = count_q + wfc_pkg::CNT_W'(1);
              end
            end
            wfc_pkg::KIND_CANCEL: begin
              if (pend_q[op_i.item_id] && count_q != '0) begin
                // fetch the successor of the item first
                ram_raddr = op_i.item_id;
                id_d      = op_i.item_id;
                state_d   = ST_LINK;
              end else begin
                done_o = 1'b1;
              end
            end
            wfc_pkg::KIND_DEQ: begin
              if (count_q == '0) begin
                done_o = 1'b1;
              end else if (count_q == wfc_pkg::CNT_W'(1)) begin
                done_o          = 1'b1;
                res_o.got_item  = 1'b1;
                res_o.taken_id  = head_q;
                pend_d[head_q]  = 1'b0;
                count_d         = '0;
                head_d          = '0;
                tail_d          = '0;
              end else begin
                ram_raddr = head_q;
                id_d      = head_q;
                state_d   = ST_DEQ;
              end
            end
            default: begin
              done_o = 1'b1;
            end
          endcase
        end
      end
      ST_DEQ: begin
        done_o         = 1'b1;
        res_o.got_item = 1'b1;
        res_o.taken_id = id_q;
        head_d         = ram_rdata;
        pend_d[id_q]   = 1'b0;
        count_d        = count_q - wfc_pkg::CNT_W'(1);
        state_d        = ST_IDLE;
      end
      ST_LINK: begin
        nid_d = ram_rdata;
        if (head_q == id_q) begin
          if (count_q > wfc_pkg::CNT_W'(1)) begin
            head_d = ram_rdata;
          end
          cancel_fin = 1'b1;
        end else begin
          // start the walk for the predecessor at the head
          ram_raddr = head_q;
          prev_d    = head_q;
          state_d   = ST_WALK;
        end
      end
      ST_WALK: begin
        if (ram_rdata == id_q) begin
          ram_we    = 1'b1;
          ram_waddr = prev_q;
          ram_wdata = nid_q;
          if (tail_q == id_q) begin
            tail_d = prev_q;
          end
          cancel_fin = 1'b1;
        end else begin
          prev_d    = ram_rdata;
          ram_raddr = ram_rdata;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cancel_fin) begin
      done_o       = 1'b1;
      pend_d[id_q] = 1'b0;
      count_d      = count_q - wfc_pkg::CNT_W'(1);
      state_d      = ST_IDLE;
      if (count_q == wfc_pkg::CNT_W'(1)) begin
        head_d = '0;
        tail_d = '0;
      end
    end

    res_o.queued_count = count_d;
  end

  assign idle_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      pend_q  <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    nid_q  <= nid_d;
    prev_q <= prev_d;
  end

`ifndef SYNTHESIS
  a_count_matches_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(pend_q) == int'(count_q))
    else $error("pending marks disagree with item count");

  a_empty_ptrs_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 |-> head_q == '0 && tail_q == '0)
    else $error("empty queue with nonzero head or tail");

  a_start_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == ST_IDLE)
    else $error("operation started while busy");

  a_deq_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DEQ |-> done_o && res_o.got_item)
    else $error("dequeue did not complete after link read");
`endif

endmodule

`default_nettype wire

// File: rtl/work_fifo_with_cancel_unit.sv
// Work FIFO with cancel.
//
// Holds up to 64 work item identifiers in arrival order as a linked list in a
// 64 x 6 link RAM, with one pending flag per identifier kept in flops.
// in_i carries operations (enqueue, cancel, dequeue head); out_o returns one
// result per operation: reject status, dequeued identifier, queue depth.
//
// Work done per operation before its result is registered for out_o:
//   enqueue, empty or single-item dequeue, no-op cancel : no link RAM read
//   dequeue of a queue with two or more  : one link RAM read
//   cancel of the head item              : one link RAM read
//   cancel of the item at position k     : a successor read, then the walk from
//                                          the head at one link RAM read a cycle
// Only one operation is in flight; the next transfer is taken once the
// controller is back in idle and the output slot can take a result, so a
// steady stream of enqueues runs at one per cycle while the receiver keeps up.
// The result sits in an output register; while the receiver stalls with a
// result waiting, in_i.ready stays low, so no result is dropped or overwritten.
// Reset empties the queue and clears all pending flags at once; the link RAM
// itself is not cleared.

`default_nettype none

module work_fifo_with_cancel_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  wfc_in_if.sink     in_i,
  wfc_out_if.source  out_o
);

  wfc_pkg::op_t  op;
  wfc_pkg::res_t res;
  wfc_pkg::res_t out_q;
  logic          out_valid_q;
  logic          ctrl_idle;
  logic          ctrl_done;
  logic          start;

  // Accept a new operation only when the controller is idle and the output
  // slot is free, or is being emptied in this cycle.
  assign in_i.ready = ctrl_idle && (!out_valid_q || out_o.ready);
  assign start      = in_i.valid && in_i.ready;

  assign op.kind          = in_i.kind;
  assign op.item_id       = in_i.item_id;
  assign op.handler_valid = in_i.handler_valid;

  wfc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .op_i    (op),
    .idle_o  (ctrl_idle),
    .done_o  (ctrl_done),
    .res_o   (res)
  );

  // Output register: load on completion, drop after the transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_done) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_done) begin
      out_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_q.status;
  assign out_o.got_item     = out_q.got_item;
  assign out_o.taken_id     = out_q.taken_id;
  assign out_o.queued_count = out_q.queued_count;

`ifndef SYNTHESIS
  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_done |-> !out_valid_q || out_o.ready)
    else $error("result written over an untaken one");
`endif

endmodule

`default_nettype wire
